/* hdl/wiws_pkg.sv */
// wiws_pkg: shared types, codes and constants of the wakeup scheduler
// no dependencies; imported by every module of the block
package wiws_pkg;

   localparam int NOW_W   = 32;
   localparam int SOD_W   = 17;
   localparam int SLOT_W  = 20;
   localparam int WAIT_W  = 19;
   localparam int CSR_IDX_W = 3;
   localparam int IVL_W   = 14;

   localparam int DAY_SECONDS     = 86400;
   localparam int HOUR_SECONDS    = 3600;
   localparam int MINUTE_SECONDS  = 60;
   localparam int PREALARM_WINDOW = 30;
   localparam int SLEEP_MARGIN    = 35;
   localparam int SLEEP_MIN       = 5;
   localparam int WAKE_GUARD      = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT0 = 3'd1;

   typedef enum logic [2:0] {
      FUNC_RESCHEDULE = 3'd0,
      FUNC_POLL       = 3'd1,
      FUNC_ACK_PRE    = 3'd2,
      FUNC_WAKE       = 3'd3,
      FUNC_ACK_TRIG   = 3'd4,
      FUNC_PLAN_SLEEP = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      PLAN_NONE   = 2'd0,
      PLAN_TIMED  = 2'd1,
      PLAN_BUTTON = 2'd2
   } sleep_plan_type;

   // bit 0 is enable, bit 19 is buzzer
   typedef struct packed {
      logic       buzz;
      logic [7:0] interval;
      logic [4:0] end_hour;
      logic [4:0] start_hour;
      logic       enable;
   } slot_type;

   typedef struct packed {
      logic [2:0]       func;
      logic [NOW_W-1:0] now;
      logic [SOD_W-1:0] sod;
      logic             awake;
   } req_item_type;

   // summary of all slots for the current second of day
   typedef struct packed {
      logic                     win_valid;
      logic [7:0]               win_interval;
      logic                     win_buzz;
      logic                     found;
      logic signed [WAIT_W-1:0] best_wait;
      logic                     any_buzz;
   } slot_sum_type;

   function automatic logic [SOD_W-1:0] hour_start(input logic [4:0] hour);
      return SOD_W'(hour) * SOD_W'(HOUR_SECONDS);
   endfunction

endpackage

/* hdl/wiws_cfg.sv */
// wiws_cfg: mode and schedule slot registers behind the write port
// depends on wiws_pkg
module wiws_cfg
   import wiws_pkg::*;
#(
   parameter int NUM_SLOTS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [SLOT_W-1:0]             csr_wdata,
   output logic                          mode,
   output slot_type [NUM_SLOTS-1:0]      slots
);

   logic                     mode_ff;
   slot_type [NUM_SLOTS-1:0] slots_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         slots_ff <= '0;
      end else if (csr_we) begin
         if (csr_index == CSR_MODE) begin
            mode_ff <= csr_wdata[0];
         end
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (csr_index == CSR_SLOT0 + CSR_IDX_W'(i)) begin
               slots_ff[i] <= slot_type'(csr_wdata);
            end
         end
      end
   end

   assign mode  = mode_ff;
   assign slots = slots_ff;

endmodule

/* hdl/wiws_slots.sv */
// wiws_slots: per-slot window match, winning slot and earliest slot start
// depends on wiws_pkg
module wiws_slots
   import wiws_pkg::*;
#(
   parameter int NUM_SLOTS = 4
) (
   input  slot_type [NUM_SLOTS-1:0] slots,
   input  logic [SOD_W-1:0]         sod,
   output slot_sum_type             sum
);

   logic [NUM_SLOTS-1:0]     in_win;
   logic signed [WAIT_W-1:0] wait_s [NUM_SLOTS];

   // hour >= h is the same as sod >= h*3600, so no division is needed
   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         logic [SOD_W-1:0]         s_sec;
         logic [SOD_W-1:0]         e_sec;
         logic signed [WAIT_W-1:0] raw;
         s_sec = hour_start(slots[i].start_hour);
         e_sec = hour_start(slots[i].end_hour);
         if (slots[i].start_hour == slots[i].end_hour) begin
            in_win[i] = 1'b1;
         end else if (slots[i].start_hour < slots[i].end_hour) begin
            in_win[i] = (sod >= s_sec) && (sod < e_sec);
         end else begin
            in_win[i] = (sod >= s_sec) || (sod < e_sec);
         end
         raw = $signed({2'b00, s_sec}) - $signed({2'b00, sod});
         // a start not after now moves to tomorrow
         if (raw <= 0) begin
            wait_s[i] = raw + WAIT_W'(DAY_SECONDS);
         end else begin
            wait_s[i] = raw;
         end
      end
   end

   always_comb begin
      sum = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (slots[i].enable && in_win[i]) begin
            sum.win_valid    = 1'b1;
            sum.win_interval = slots[i].interval;
            sum.win_buzz     = slots[i].buzz;
         end
         if (slots[i].enable && (!sum.found || wait_s[i] < sum.best_wait)) begin
            sum.found     = 1'b1;
            sum.best_wait = wait_s[i];
         end
         if (slots[i].enable && slots[i].buzz) begin
            sum.any_buzz = 1'b1;
         end
      end
   end

endmodule

/* hdl/wiws_core.sv */
// wiws_core: scheduler state update and result register
// depends on wiws_pkg; slot summary comes from wiws_slots
module wiws_core
   import wiws_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  req_item_type         in_item,
   output logic                 in_ready,
   input  logic                 mode,
   input  slot_sum_type         sum,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [NOW_W-1:0]     rsp_next_reading,
   output logic                 rsp_pending_trigger,
   output logic                 rsp_pre_alarm,
   output logic                 rsp_buzzer_now,
   output logic                 rsp_any_buzzer,
   output logic [1:0]           rsp_sleep_plan,
   output logic [NOW_W-1:0]     rsp_sleep_seconds
);

   logic             fire;
   logic [NOW_W-1:0] next_time_ff, next_time_in;
   logic [NOW_W-1:0] acked_ff, acked_in;
   logic             trig_ff, trig_in;
   logic             pre_ff, pre_in;
   logic [NOW_W-1:0] resched_time;
   logic [NOW_W-1:0] diff;
   logic [IVL_W-1:0] ivl_sec;
   sleep_plan_type   plan_in;
   logic [NOW_W-1:0] sleep_in;
   logic             pend_in, pre_out_in, bz_now_in;

   logic             rsp_valid_ff;
   logic [NOW_W-1:0] rsp_next_ff;
   logic             rsp_pend_ff, rsp_pre_ff, rsp_bz_now_ff, rsp_bz_any_ff;
   logic [1:0]       rsp_plan_ff;
   logic [NOW_W-1:0] rsp_sleep_ff;

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign fire     = in_valid && in_ready;

   assign ivl_sec = IVL_W'(sum.win_interval) * IVL_W'(MINUTE_SECONDS);

   always_comb begin
      if (sum.win_valid && sum.win_interval != 8'd0) begin
         resched_time = in_item.now + NOW_W'(ivl_sec);
      end else if (sum.found) begin
         resched_time = in_item.now + {{(NOW_W-WAIT_W){sum.best_wait[WAIT_W-1]}},
                                       sum.best_wait};
      end else begin
         resched_time = '0;
      end
   end

   always_comb begin
      next_time_in = next_time_ff;
      acked_in     = acked_ff;
      trig_in      = trig_ff;
      pre_in       = pre_ff;
      plan_in      = PLAN_NONE;
      case (func_type'(in_item.func))
         FUNC_RESCHEDULE: begin
            next_time_in = resched_time;
         end
         FUNC_ACK_PRE: begin
            pre_in   = 1'b0;
            acked_in = next_time_ff;
         end
         FUNC_WAKE: begin
            if (next_time_ff != '0 &&
                {1'b0, next_time_ff} > {1'b0, in_item.now} + (NOW_W+1)'(WAKE_GUARD)) begin
               pre_in  = 1'b1;
               trig_in = 1'b0;
            end else begin
               trig_in = 1'b1;
               pre_in  = 1'b0;
            end
         end
         FUNC_ACK_TRIG: begin
            trig_in = 1'b0;
         end
         FUNC_PLAN_SLEEP: begin
            if (in_item.awake) begin
               plan_in = PLAN_NONE;
            end else if (mode && next_time_ff != '0) begin
               // reading time already passed: pick the next one first
               if (next_time_ff <= in_item.now) begin
                  next_time_in = resched_time;
               end
               plan_in = (next_time_in == '0) ? PLAN_BUTTON : PLAN_TIMED;
            end else begin
               plan_in = PLAN_BUTTON;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      diff = next_time_in - in_item.now;
      sleep_in = '0;
      if (plan_in == PLAN_TIMED) begin
         if (diff > NOW_W'(SLEEP_MARGIN)) begin
            sleep_in = diff - NOW_W'(PREALARM_WINDOW);
         end else if (diff < NOW_W'(SLEEP_MIN)) begin
            sleep_in = NOW_W'(SLEEP_MIN);
         end else begin
            sleep_in = diff;
         end
      end
      pend_in    = mode && (trig_in || (next_time_in != '0 && in_item.now >= next_time_in));
      pre_out_in = mode && next_time_in != '0 &&
                   (pre_in || (in_item.now < next_time_in &&
                               diff <= NOW_W'(PREALARM_WINDOW) &&
                               acked_in != next_time_in));
      bz_now_in  = mode && sum.win_valid && sum.win_buzz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_time_ff <= '0;
         acked_ff     <= '0;
         trig_ff      <= 1'b0;
         pre_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            next_time_ff <= next_time_in;
            acked_ff     <= acked_in;
            trig_ff      <= trig_in;
            pre_ff       <= pre_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_next_ff   <= next_time_in;
         rsp_pend_ff   <= pend_in;
         rsp_pre_ff    <= pre_out_in;
         rsp_bz_now_ff <= bz_now_in;
         rsp_bz_any_ff <= sum.any_buzz;
         rsp_plan_ff   <= plan_in;
         rsp_sleep_ff  <= sleep_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_next_reading    = rsp_next_ff;
   assign rsp_pending_trigger = rsp_pend_ff;
   assign rsp_pre_alarm       = rsp_pre_ff;
   assign rsp_buzzer_now      = rsp_bz_now_ff;
   assign rsp_any_buzzer      = rsp_bz_any_ff;
   assign rsp_sleep_plan      = rsp_plan_ff;
   assign rsp_sleep_seconds   = rsp_sleep_ff;

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(next_time_ff) && $stable(trig_ff) && $stable(pre_ff))
      else $error("scheduler state changed without a transfer");

   a_ack_trig: assert property (@(posedge clock) disable iff (reset)
      fire && in_item.func == FUNC_ACK_TRIG |=> !trig_ff)
      else $error("trigger flag survived its acknowledge");

   a_ack_pre: assert property (@(posedge clock) disable iff (reset)
      fire && in_item.func == FUNC_ACK_PRE |=> !pre_ff && acked_ff == $past(next_time_ff))
      else $error("pre-alarm acknowledge not recorded");

   a_wake_flags: assert property (@(posedge clock) disable iff (reset)
      fire && in_item.func == FUNC_WAKE |=> trig_ff != pre_ff)
      else $error("timer wake must set exactly one flag");

   a_sleep_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_plan_ff == PLAN_TIMED) ? (rsp_sleep_ff >= NOW_W'(SLEEP_MIN))
                                                   : (rsp_sleep_ff == '0))
      else $error("sleep length inconsistent with plan");

endmodule

/* hdl/windowed_interval_wakeup_scheduler.sv */
// windowed_interval_wakeup_scheduler: top level of the wakeup scheduler
// depends on wiws_pkg, wiws_cfg, wiws_slots and wiws_core
//
// Usage:
//  - csr_ write port: index 0 is mode enable, indexes 1..4 the schedule slots
//    (bit 0 enable, bits 5:1 start hour, 10:6 end hour, 18:11 interval in
//    minutes, bit 19 buzzer). Writes take effect at once; write only when idle.
//  - req_ channel: one event per transfer (func, epoch seconds, second of day,
//    stay awake). rsp_ channel: one result per event, in order.
//  - data path: the req_ transfer loads the input register, and the result register
//    then captures the event's result, which rsp_ presents.
//  - throughput: one event per cycle while rsp_ready is high; the state update
//    for an event is combinational between the input and result registers and
//    is registered with the result, so the next event sees it directly.
//  - if rsp_ready is held low the result register holds, one more event waits
//    in the input register, then req_ready drops until the result is taken.
//  - reset clears the mode, all slots, the reading time, the acknowledged
//    pre-alarm time and both timer flags; no result is pending after reset.
module windowed_interval_wakeup_scheduler
   import wiws_pkg::*;
#(
   parameter int NUM_SLOTS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SLOT_W-1:0]    csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_func,
   input  logic [NOW_W-1:0]     req_now_seconds,
   input  logic [SOD_W-1:0]     req_second_of_day,
   input  logic                 req_stay_awake,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [NOW_W-1:0]     rsp_next_reading,
   output logic                 rsp_pending_trigger,
   output logic                 rsp_pre_alarm,
   output logic                 rsp_buzzer_now,
   output logic                 rsp_any_buzzer,
   output logic [1:0]           rsp_sleep_plan,
   output logic [NOW_W-1:0]     rsp_sleep_seconds
);

   logic                     in_valid_ff, in_valid_in;
   req_item_type             in_item_ff;
   logic                     core_ready;
   logic                     mode;
   slot_type [NUM_SLOTS-1:0] slots;
   slot_sum_type             sum;

   assign req_ready   = !in_valid_ff || core_ready;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= '{func:  req_func,
                         now:   req_now_seconds,
                         sod:   req_second_of_day,
                         awake: req_stay_awake};
      end
   end

   wiws_cfg #(.NUM_SLOTS(NUM_SLOTS)) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .mode      (mode),
      .slots     (slots)
   );

   wiws_slots #(.NUM_SLOTS(NUM_SLOTS)) u_slots (
      .slots (slots),
      .sod   (in_item_ff.sod),
      .sum   (sum)
   );

   wiws_core u_core (
      .clock               (clock),
      .reset               (reset),
      .in_valid            (in_valid_ff),
      .in_item             (in_item_ff),
      .in_ready            (core_ready),
      .mode                (mode),
      .sum                 (sum),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_next_reading    (rsp_next_reading),
      .rsp_pending_trigger (rsp_pending_trigger),
      .rsp_pre_alarm       (rsp_pre_alarm),
      .rsp_buzzer_now      (rsp_buzzer_now),
      .rsp_any_buzzer      (rsp_any_buzzer),
      .rsp_sleep_plan      (rsp_sleep_plan),
      .rsp_sleep_seconds   (rsp_sleep_seconds)
   );

endmodule
